[src/per_pkg.sv]
// Package for presence_envelope_reward: sequencer state type, register
// indexes and Q1.15 constants. No dependencies.
`default_nettype none
package per_pkg;

    localparam int unsigned Q_W = 16;
    localparam logic [Q_W-1:0] Q_ONE = 16'h8000;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEPS     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEPS       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_INCREMENT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_DECREMENT  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_LIMIT       = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_THRESHOLD  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WEIGHT  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SOUND_WEIGHT     = 8'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_SND,
        ST_FACE,
        ST_SUM
    } state_t;

endpackage
`default_nettype wire

[src/presence_envelope_reward_top.sv]
// Presence envelope reward. Each input transaction is one timestep: a presence
// bit and an optional Q1.15 sound level (32768 = 1.0). The block keeps a run
// counter of presence steps (cleared once more than miss_limit steps in a row
// are missed), drives an attack/hold/decay envelope clamped to 0..1.0 from it,
// maps sound to a reward (squared at or below threshold, 1.0 above), and
// returns the weighted sum saturated at 1.0 together with the new envelope.
// One registered 16x16 multiplier is shared over the three products under a
// small sequencer: after acceptance an item passes through the envelope update
// and one step per product before the next item can be accepted; the last step
// waits while the output register holds a result that m_tready has not taken.
// Configuration writes are always taken; write only while the block is idle.
// Depends on per_pkg and per_mul.
`default_nettype none
module presence_envelope_reward_top #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [0] presence_seen, [16:1] sound_level, zero pad
    input  wire logic        s_tuser,   // [0] sound_valid
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [15:0] total_reward, [31:16] envelope_level
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [per_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [per_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned QW = per_pkg::Q_W;
    // compare width for run count against attack + hold (9-bit sum)
    localparam int unsigned CMP_W = (COUNT_WIDTH > 9) ? COUNT_WIDTH : 9;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // ---------------- configuration registers ----------------
    logic [7:0]    attack_steps_reg;
    logic [7:0]    hold_steps_reg;
    logic [QW-1:0] attack_increment_reg;
    logic [QW-1:0] decay_decrement_reg;
    logic [7:0]    miss_limit_reg;
    logic [QW-1:0] sound_threshold_reg;
    logic [QW-1:0] presence_weight_reg;
    logic [QW-1:0] sound_weight_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_steps_reg     <= 8'd4;
            hold_steps_reg       <= 8'd2;
            attack_increment_reg <= 16'd8192;
            decay_decrement_reg  <= 16'd1820;
            miss_limit_reg       <= 8'd3;
            sound_threshold_reg  <= 16'd21955;
            presence_weight_reg  <= 16'd24576;
            sound_weight_reg     <= 16'd24576;
        end else if (cfg_valid && cfg_ready) begin
            // unknown indexes are dropped
            if (cfg_index == per_pkg::REG_ATTACK_STEPS)     attack_steps_reg <= cfg_data[7:0];
            if (cfg_index == per_pkg::REG_HOLD_STEPS)       hold_steps_reg <= cfg_data[7:0];
            if (cfg_index == per_pkg::REG_ATTACK_INCREMENT) attack_increment_reg <= cfg_data;
            if (cfg_index == per_pkg::REG_DECAY_DECREMENT)  decay_decrement_reg <= cfg_data;
            if (cfg_index == per_pkg::REG_MISS_LIMIT)       miss_limit_reg <= cfg_data[7:0];
            if (cfg_index == per_pkg::REG_SOUND_THRESHOLD)  sound_threshold_reg <= cfg_data;
            if (cfg_index == per_pkg::REG_PRESENCE_WEIGHT)  presence_weight_reg <= cfg_data;
            if (cfg_index == per_pkg::REG_SOUND_WEIGHT)     sound_weight_reg <= cfg_data;
        end
    end

    // ---------------- state ----------------
    per_pkg::state_t          state_reg, state_next;
    logic [COUNT_WIDTH-1:0]   run_count_reg, run_count_next;
    logic [7:0]               miss_count_reg, miss_count_next;
    logic [QW-1:0]            envelope_reg, envelope_next;
    logic [QW-1:0]            level_reg, level_next;    // sound level, 0 when not valid
    logic [QW-1:0]            snd_reg, snd_next;        // sound reward, <= 1.0
    logic [QW:0]              face_reg, face_next;      // weighted envelope
    logic                     m_valid_reg, m_valid_next;
    logic [31:0]              m_data_reg, m_data_next;

    // shared multiplier
    logic [QW-1:0]   mul_a, mul_b;
    logic [2*QW-1:0] mul_p;
    logic [QW:0]     prod_q;   // product >> 15

    per_mul u_mul (
        .aclk  (aclk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    assign prod_q = mul_p[2*QW-1:QW-1];

    // envelope helpers
    logic [CMP_W-1:0] run_ext, attack_ext, hold_end_ext;
    logic [QW:0]      rise_sum;
    logic [QW-1:0]    rise_val, fall_val;
    logic [QW+1:0]    total_sum;
    logic             out_free;

    assign run_ext      = CMP_W'(run_count_reg);
    assign attack_ext   = CMP_W'(attack_steps_reg);
    assign hold_end_ext = CMP_W'({1'b0, attack_steps_reg} + {1'b0, hold_steps_reg});
    assign rise_sum     = {1'b0, envelope_reg} + {1'b0, attack_increment_reg};
    assign rise_val     = (rise_sum > {1'b0, per_pkg::Q_ONE}) ? per_pkg::Q_ONE
                                                              : rise_sum[QW-1:0];
    assign fall_val     = (envelope_reg > decay_decrement_reg)
                          ? (envelope_reg - decay_decrement_reg) : '0;
    assign total_sum    = {1'b0, face_reg} + {1'b0, prod_q};
    assign out_free     = !m_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        run_count_next  = run_count_reg;
        miss_count_next = miss_count_reg;
        envelope_next   = envelope_reg;
        level_next      = level_reg;
        snd_next        = snd_reg;
        face_next       = face_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        s_tready        = 1'b0;
        mul_a           = snd_reg;
        mul_b           = sound_weight_reg;

        unique case (state_reg)
            per_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    level_next = s_tuser ? s_tdata[16:1] : '0;
                    if (s_tdata[0]) begin
                        if (run_count_reg != COUNT_MAX) run_count_next = run_count_reg + 1'b1;
                        miss_count_next = '0;
                    end else if (miss_count_reg >= miss_limit_reg) begin
                        run_count_next  = '0;
                        miss_count_next = '0;
                    end else if (miss_count_reg != 8'hFF) begin
                        miss_count_next = miss_count_reg + 1'b1;
                    end
                    state_next = per_pkg::ST_ENV;
                end
            end
            per_pkg::ST_ENV: begin
                // envelope from the updated run count; start level squared
                priority if (run_count_reg == '0)    envelope_next = fall_val;
                else if (run_ext < attack_ext)       envelope_next = rise_val;
                else if (run_ext < hold_end_ext)     envelope_next = per_pkg::Q_ONE;
                else                                 envelope_next = fall_val;
                mul_a      = level_reg;
                mul_b      = level_reg;
                state_next = per_pkg::ST_SND;
            end
            per_pkg::ST_SND: begin
                if (level_reg > sound_threshold_reg)      snd_next = per_pkg::Q_ONE;
                else if (prod_q > {1'b0, per_pkg::Q_ONE}) snd_next = per_pkg::Q_ONE;
                else                                      snd_next = prod_q[QW-1:0];
                mul_a      = envelope_reg;
                mul_b      = presence_weight_reg;
                state_next = per_pkg::ST_FACE;
            end
            per_pkg::ST_FACE: begin
                face_next  = prod_q;
                state_next = per_pkg::ST_SUM;
            end
            per_pkg::ST_SUM: begin
                // operands held, so the product stays put while the output is busy
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next[QW-1:0] = (total_sum > {2'b00, per_pkg::Q_ONE})
                                          ? per_pkg::Q_ONE : total_sum[QW-1:0];
                    m_data_next[2*QW-1:QW] = envelope_reg;
                    state_next = per_pkg::ST_IDLE;
                end
            end
            default: state_next = per_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= per_pkg::ST_IDLE;
            run_count_reg  <= '0;
            miss_count_reg <= '0;
            envelope_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            run_count_reg  <= run_count_next;
            miss_count_reg <= miss_count_next;
            envelope_reg   <= envelope_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg  <= level_next;
        snd_reg    <= snd_next;
        face_reg   <= face_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    // a new result only comes out of the final sequencer step
    a_result_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == per_pkg::ST_SUM))
        else $error("result appeared outside the sum step");

    // both outputs stay within 0..1.0
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= per_pkg::Q_ONE && m_tdata[31:16] <= per_pkg::Q_ONE))
        else $error("result above 1.0");

    // an accepted item always enters the envelope step next
    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == per_pkg::ST_ENV))
        else $error("accepted item did not start the sequence");

    // envelope register never leaves its clamp range
    a_env_range: assert property (@(posedge aclk) disable iff (!aresetn)
        envelope_reg <= per_pkg::Q_ONE)
        else $error("envelope above 1.0");

endmodule
`default_nettype wire

[src/per_mul.sv]
// Shared 16x16 unsigned multiplier with a registered product.
// Uses per_pkg for the operand width.
`default_nettype none
module per_mul (
    input  wire logic                         aclk,
    input  wire logic [per_pkg::Q_W-1:0]      a,
    input  wire logic [per_pkg::Q_W-1:0]      b,
    output logic      [2*per_pkg::Q_W-1:0]    p_reg
);

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule
`default_nettype wire

[bench/presence_envelope_reward_top_test.sv]
// Self-checking bench for presence_envelope_reward_top: stream stimulus, config writes,
// and a scoreboard class that predicts each reward and envelope transaction.
// Depends on per_pkg and the RTL under src/.
`default_nettype none
module presence_envelope_reward_top_test;

    localparam int unsigned COUNT_W = 16;
    // Cycles without any accepted transaction before the run is called hung.
    // The longest legal quiet stretch is the receiver hold-off.
    localparam int unsigned STALL_LIMIT = 4000;
    // Indexes with no register behind them; writes there must change nothing.
    localparam logic [per_pkg::CFG_IDX_W-1:0] REG_UNMAPPED  = 8'd8;
    localparam logic [per_pkg::CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

    // Packed to match m_tdata: envelope_level in the upper half.
    typedef struct packed {
        logic [15:0] envelope_level;
        logic [15:0] total_reward;
    } reward_item_t;

    // Predicts the reward and envelope for each accepted timestep and keeps
    // the expected transactions in order until the result stream shows them.
    class reward_scoreboard;
        logic [7:0]         attack_steps;
        logic [7:0]         hold_steps;
        logic [15:0]        attack_inc;
        logic [15:0]        decay_dec;
        logic [7:0]         miss_limit;
        logic [15:0]        snd_threshold;
        logic [15:0]        pres_weight;
        logic [15:0]        snd_weight;
        logic [COUNT_W-1:0] run_count;
        logic [7:0]         miss_count;
        logic [15:0]        envelope;
        reward_item_t       expected_q[$];
        int                 mismatches;

        function new();
            attack_steps  = 8'd4;
            hold_steps    = 8'd2;
            attack_inc    = 16'd8192;
            decay_dec     = 16'd1820;
            miss_limit    = 8'd3;
            snd_threshold = 16'd21955;
            pres_weight   = 16'd24576;
            snd_weight    = 16'd24576;
            run_count     = '0;
            miss_count    = '0;
            envelope      = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [per_pkg::CFG_IDX_W-1:0] idx,
                                logic [per_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                per_pkg::REG_ATTACK_STEPS:     attack_steps  = data[7:0];
                per_pkg::REG_HOLD_STEPS:       hold_steps    = data[7:0];
                per_pkg::REG_ATTACK_INCREMENT: attack_inc    = data;
                per_pkg::REG_DECAY_DECREMENT:  decay_dec     = data;
                per_pkg::REG_MISS_LIMIT:       miss_limit    = data[7:0];
                per_pkg::REG_SOUND_THRESHOLD:  snd_threshold = data;
                per_pkg::REG_PRESENCE_WEIGHT:  pres_weight   = data;
                per_pkg::REG_SOUND_WEIGHT:     snd_weight    = data;
                default: ;
            endcase
        endfunction

        function void note_input(bit seen, bit sound_ok, logic [15:0] level_in);
            longint unsigned level, snd, face_part, snd_part, total;
            int unsigned     env, hold_end;
            reward_item_t    item;
            level = sound_ok ? longint'(level_in) : 0;
            // counters first
            if (seen) begin
                if (run_count != {COUNT_W{1'b1}})
                    run_count = run_count + 1'b1;
                miss_count = '0;
            end else if (miss_count >= miss_limit) begin
                run_count  = '0;
                miss_count = '0;
            end else if (miss_count != 8'hFF) begin
                miss_count = miss_count + 1'b1;
            end
            // envelope from the new run count
            env      = envelope;
            hold_end = int'(attack_steps) + int'(hold_steps);
            if (run_count == 0)
                env = (env > decay_dec) ? env - decay_dec : 0;
            else if (run_count < attack_steps)
                env = (env + attack_inc > per_pkg::Q_ONE) ? per_pkg::Q_ONE : env + attack_inc;
            else if (int'(run_count) < hold_end)
                env = per_pkg::Q_ONE;
            else
                env = (env > decay_dec) ? env - decay_dec : 0;
            envelope = env[15:0];
            // sound reward: full above threshold, squared otherwise
            if (level > snd_threshold) begin
                snd = per_pkg::Q_ONE;
            end else begin
                snd = (level * level) >> 15;
                if (snd > per_pkg::Q_ONE)
                    snd = per_pkg::Q_ONE;
            end
            face_part = (longint'(envelope) * pres_weight) >> 15;
            snd_part  = (snd * snd_weight) >> 15;
            total     = face_part + snd_part;
            if (total > per_pkg::Q_ONE)
                total = per_pkg::Q_ONE;
            item.total_reward   = total[15:0];
            item.envelope_level = envelope;
            expected_q.push_back(item);
        endfunction

        function void check_result(logic [31:0] data);
            reward_item_t got, want;
            got = data;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %h with no transaction pending", data);
                return;
            end
            want = expected_q.pop_front();
            if (got.total_reward !== want.total_reward ||
                got.envelope_level !== want.envelope_level) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: total_reward exp %0d got %0d, envelope_level exp %0d got %0d",
                             want.total_reward, got.total_reward,
                             want.envelope_level, got.envelope_level);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [23:0]                    s_tdata;    // [0] presence_seen, [16:1] sound_level, zero pad
    logic                           s_tuser;    // [0] sound_valid
    logic                           m_tvalid;
    logic                           m_tready;
    logic [31:0]                    m_tdata;    // [15:0] total_reward, [31:16] envelope_level
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [per_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [per_pkg::CFG_DATA_W-1:0] cfg_data;

    reward_scoreboard sb;
    int unsigned      s_idle_pct;      // sender gap chance per cycle, percent
    int unsigned      m_idle_pct;      // receiver stall chance per cycle, percent
    int unsigned      rx_hold_cycles;  // long receiver hold-off, consumed by the receiver
    int unsigned      quiet_cycles;

    presence_envelope_reward_top #(.COUNT_WIDTH(COUNT_W)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result monitor: every accepted result goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: only cycles with no transaction on any channel count.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles + 1 >= STALL_LIMIT) begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long counted hold-off when requested.
    initial begin : receiver
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready = 1'b0;
                rx_hold_cycles--;
            end else begin
                m_tready = ($urandom_range(99) >= m_idle_pct);
            end
        end
    end

    // All drive tasks start and end at a falling edge.
    task automatic cfg_write(logic [per_pkg::CFG_IDX_W-1:0] idx,
                             logic [per_pkg::CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic apply_setting(logic [7:0] att, logic [7:0] hold, logic [15:0] inc,
                                 logic [15:0] dec, logic [7:0] miss, logic [15:0] thr,
                                 logic [15:0] pw, logic [15:0] sw);
        cfg_write(per_pkg::REG_ATTACK_STEPS,     {8'h00, att});
        cfg_write(per_pkg::REG_HOLD_STEPS,       {8'h00, hold});
        cfg_write(per_pkg::REG_ATTACK_INCREMENT, inc);
        cfg_write(per_pkg::REG_DECAY_DECREMENT,  dec);
        cfg_write(per_pkg::REG_MISS_LIMIT,       {8'h00, miss});
        cfg_write(per_pkg::REG_SOUND_THRESHOLD,  thr);
        cfg_write(per_pkg::REG_PRESENCE_WEIGHT,  pw);
        cfg_write(per_pkg::REG_SOUND_WEIGHT,     sw);
        cfg_valid = 1'b0;
    endtask

    // Offers one timestep; valid stays high into the next item unless a gap is drawn.
    task automatic send_step(bit seen, bit sound_ok, logic [15:0] level);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, level, seen};
        s_tuser  = sound_ok;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(seen, sound_ok, level);
        @(negedge aclk);
    endtask

    // Block is idle once the last expected result is out.
    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_level(logic [15:0] thr);
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(16'hFFFF);
            1: v = int'(thr) + int'($urandom_range(8)) - 4;  // straddle the threshold
            2: v = $urandom_range(32768);
            default: begin
                case ($urandom_range(3))
                    0: v = 0;
                    1: v = 32768;
                    2: v = 16'hFFFF;
                    default: v = $urandom_range(255);
                endcase
            end
        endcase
        if (v < 0) v = 0;
        if (v > 16'hFFFF) v = 16'hFFFF;
        return v[15:0];
    endfunction

    // Mostly presence bursts of random length up to past attack and hold, and miss
    // bursts around the miss limit; the rest is random noise.
    task automatic run_random(int n);
        int  left, kind, r, i;
        bit  seen;
        left = 0;
        kind = 0;
        for (i = 0; i < n; i++) begin
            if (left == 0) begin
                r = $urandom_range(99);
                if (r < 60) begin
                    kind = 0;
                    left = 1 + $urandom_range(int'(sb.attack_steps) + int'(sb.hold_steps) + 6);
                end else if (r < 90) begin
                    kind = 1;
                    left = 1 + $urandom_range(int'(sb.miss_limit) + 2);
                end else begin
                    kind = 2;
                    left = 1 + $urandom_range(9);
                end
            end
            left--;
            seen = (kind == 0) ? 1'b1 : (kind == 1) ? 1'b0 : 1'($urandom_range(1));
            send_step(seen, $urandom_range(99) < 70, pick_level(sb.snd_threshold));
        end
    endtask

    task automatic random_setting();
        apply_setting(8'($urandom_range(12, 1)), 8'($urandom_range(6)),
                      16'($urandom_range(32768)), 16'($urandom_range(8000)),
                      8'($urandom_range(5)), 16'($urandom_range(32768)),
                      16'($urandom_range(32768)), 16'($urandom_range(32768)));
    endtask

    initial begin : main
        int i;
        sb             = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_idle_pct     = 0;
        m_idle_pct     = 0;
        rx_hold_cycles = 0;
        quiet_cycles   = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset values written back, then unmapped indexes that must be ignored
        apply_setting(8'd4, 8'd2, 16'd8192, 16'd1820, 8'd3, 16'd21955, 16'd24576, 16'd24576);
        cfg_write(REG_UNMAPPED, 16'hFFFF);
        cfg_write(REG_TOP_INDEX, 16'h0000);
        cfg_valid = 1'b0;

        s_idle_pct = 22;
        m_idle_pct = 58;

        // directed: absence from reset, sound edges, attack, hold, decay, miss clear
        send_step(1'b0, 1'b0, 16'hFFFF);   // invalid sound ignored
        send_step(1'b0, 1'b1, 16'h0000);
        send_step(1'b1, 1'b1, 16'h0000);
        send_step(1'b1, 1'b1, 16'h0001);
        send_step(1'b1, 1'b1, 16'd21955);  // at threshold: squared
        send_step(1'b1, 1'b1, 16'd21956);  // just above: full
        send_step(1'b1, 1'b1, 16'd32768);  // hold at 1.0
        send_step(1'b1, 1'b1, 16'hFFFF);   // hold ends, decay
        send_step(1'b1, 1'b0, 16'hAAAA);
        send_step(1'b0, 1'b1, 16'h5555);   // misses within the limit
        send_step(1'b0, 1'b1, 16'h8000);
        send_step(1'b0, 1'b1, 16'h7FFF);
        send_step(1'b0, 1'b0, 16'h0000);   // one miss too many: run clears
        send_step(1'b1, 1'b1, 16'hAAAA);
        send_step(1'b0, 1'b1, 16'h5555);
        send_step(1'b1, 1'b1, 16'hFFFF);
        send_step(1'b1, 1'b1, 16'd21955);
        send_step(1'b1, 1'b0, 16'h0000);
        run_random(250);

        // low extremes: no hold phase, zero steps, zero weights
        drain();
        apply_setting(8'd1, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        run_random(150);

        // high extremes, roles of the idle rates swapped
        drain();
        apply_setting(8'd255, 8'd255, 16'd32768, 16'd32768, 8'd255, 16'd32768,
                      16'd32768, 16'd32768);
        s_idle_pct = 58;
        m_idle_pct = 22;
        run_random(350);

        // zero attack steps (hold from the first presence) and values above 1.0
        drain();
        apply_setting(8'd0, 8'd3, 16'hFFFF, 16'hFFFF, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(250);

        // no idling; the first setting starts with a long receiver hold-off so
        // the output register fills and the input stalls
        s_idle_pct = 0;
        m_idle_pct = 0;
        for (i = 0; i < 3; i++) begin
            drain();
            random_setting();
            if (i == 0)
                rx_hold_cycles = 300;
            run_random(250);
        end

        // long unbroken presence run through attack and hold deep into decay
        drain();
        apply_setting(8'd4, 8'd2, 16'd8192, 16'd1820, 8'd3, 16'd21955, 16'd24576, 16'd24576);
        for (i = 0; i < 100; i++)
            send_step(1'b1, 1'($urandom_range(1)), pick_level(sb.snd_threshold));
        run_random(50);

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
